// ===== rtl/gwpc_pkg.sv =====
// ----------------------------------------------------------------------------
// gwpc_pkg
// Shared constants and types for the grid word path counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gwpc_pkg;

  localparam int MAX_ROWS = 128;
  localparam int MAX_COLS = 128;
  localparam int MAX_WORD = 128;
  localparam int CELLS    = MAX_ROWS * MAX_COLS;

  localparam int ADDR_W  = $clog2(CELLS);
  localparam int FILL_W  = $clog2(CELLS + 1);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int WORD_AW = $clog2(MAX_WORD);
  localparam int WLEN_W  = $clog2(MAX_WORD + 1);
  localparam int DIM_W   = 8;
  localparam int JUMP_W  = 7;
  localparam int SYM_W   = 8;
  localparam int COUNT_W = 64;
  localparam int CMP_W   = ADDR_W + 2;

  localparam logic [1:0] KIND_CELL   = 2'd0;
  localparam logic [1:0] KIND_LETTER = 2'd1;
  localparam logic [1:0] KIND_START  = 2'd2;

  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;
  localparam logic [1:0] REG_JUMP = 2'd2;

  typedef struct packed {
    logic clear;
    logic add;
    logic flag_clr;
  } acc_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/gwpc_ram.sv =====
// ----------------------------------------------------------------------------
// gwpc_ram
// Generic single-write, single-read memory with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gwpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/gwpc_acc.sv =====
// ----------------------------------------------------------------------------
// gwpc_acc
// Shared saturating 64-bit accumulator with a sticky overflow flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gwpc_acc
  import gwpc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire acc_ctrl_t          ctrl,
  input  wire logic [COUNT_W-1:0] operand,
  output logic      [COUNT_W-1:0] acc,
  output logic                    flag
);

  logic [COUNT_W:0] sum;

  assign sum = {1'b0, acc} + {1'b0, operand};

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.add) begin
      acc <= sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
    end
    if (rst || ctrl.flag_clr) begin
      flag <= 1'b0;
    end else if (ctrl.add && sum[COUNT_W]) begin
      flag <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/grid_word_path_counter_top.sv =====
// ----------------------------------------------------------------------------
// grid_word_path_counter_top
// Counts the paths that spell a word on a character grid with straight jumps.
// ----------------------------------------------------------------------------
// Items enter on kind/symbol and are taken at a clock edge with start high and
// busy low. Cell and letter loads give no result. A start item runs the
// layered count and raises done for one cycle with path_count and overflowed;
// the receiver cannot stall, so the result is dropped if not taken in that
// cycle. An empty word answers in the cycle right after the start item is
// taken, and busy stays low. Otherwise busy stays high while the run goes on.
// Each layer visits every cell in use through S_CELL and S_CMP. A cell that
// matches the letter of a later layer then tries every candidate neighbor
// (4 * jump_limit of them, a zero limit counting as 1) in S_NADDR, reads and
// adds each one inside the grid in S_NREAD and S_NACC and writes the sum in
// S_WRITE, all through one read port of the count memory and one shared
// saturating adder. The final sum visits every cell through S_SUMA and S_SUMB,
// and done follows from S_EMIT. The configuration channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data) is always ready; write it only while idle.
// Reset clears the registers to 1, the grid fill count and word length to
// zero; the memories are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grid_word_path_counter_top
  import gwpc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         kind,
  input  wire logic [SYM_W-1:0]   symbol,
  output logic                    done,
  output logic      [COUNT_W-1:0] path_count,
  output logic                    overflowed,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [DIM_W-1:0]   cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_CELL, S_CMP, S_NADDR, S_NREAD, S_NACC, S_WRITE,
    S_SUMA, S_SUMB, S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    DIR_UP, DIR_DOWN, DIR_LEFT, DIR_RIGHT
  } dir_t;

  state_t state;
  dir_t   dir;

  logic [DIM_W-1:0]   grid_rows, grid_cols;
  logic [JUMP_W-1:0]  jump_limit;
  logic [FILL_W-1:0]  grid_fill_pointer;
  logic [WLEN_W-1:0]  word_length;
  logic [ADDR_W-1:0]  c, nb_addr, dcols;
  logic [ROW_W-1:0]   r;
  logic [COL_W-1:0]   q;
  logic [WORD_AW-1:0] l;
  logic [JUMP_W-1:0]  d;
  logic               sel;

  logic [DIM_W-1:0]   rows_eff, cols_eff;
  logic [JUMP_W-1:0]  jl_eff;
  logic               accept, grid_we, word_we;
  logic [SYM_W-1:0]   grid_rdata, word_rdata;
  logic [COUNT_W-1:0] bank0_rdata, bank1_rdata, prev_rdata, cnt_wdata;
  logic               cnt_we, we0, we1, match, last_cell, last_layer, nb_last;
  logic               nb_valid;
  logic [ADDR_W-1:0]  nb_calc;
  acc_ctrl_t          acc_ctrl;
  logic [COUNT_W-1:0] acc;
  logic               acc_flag;

  assign busy      = (state != S_IDLE) && (state != S_EMIT);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign rows_eff = (grid_rows == '0) ? DIM_W'(1) :
                    (CMP_W'(grid_rows) > CMP_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : grid_rows;
  assign cols_eff = (grid_cols == '0) ? DIM_W'(1) :
                    (CMP_W'(grid_cols) > CMP_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : grid_cols;
  assign jl_eff   = (jump_limit == '0) ? JUMP_W'(1) : jump_limit;

  assign grid_we = accept && (kind == KIND_CELL) && (grid_fill_pointer < FILL_W'(CELLS));
  assign word_we = accept && (kind == KIND_LETTER) && (CMP_W'(word_length) < CMP_W'(MAX_WORD));

  assign match      = (grid_rdata == word_rdata);
  assign last_cell  = (CMP_W'(r) + CMP_W'(1) == CMP_W'(rows_eff)) &&
                      (CMP_W'(q) + CMP_W'(1) == CMP_W'(cols_eff));
  assign last_layer = (CMP_W'(l) + CMP_W'(1) == CMP_W'(word_length));
  assign nb_last    = (dir == DIR_RIGHT) && (d == jl_eff);
  assign prev_rdata = sel ? bank1_rdata : bank0_rdata;

  always_comb begin
    nb_valid = 1'b0;
    nb_calc  = c;
    unique case (dir)
      DIR_UP: begin
        nb_valid = CMP_W'(r) >= CMP_W'(d);
        nb_calc  = c - dcols;
      end
      DIR_DOWN: begin
        nb_valid = CMP_W'(r) + CMP_W'(d) < CMP_W'(rows_eff);
        nb_calc  = c + dcols;
      end
      DIR_LEFT: begin
        nb_valid = CMP_W'(q) >= CMP_W'(d);
        nb_calc  = c - ADDR_W'(d);
      end
      DIR_RIGHT: begin
        nb_valid = CMP_W'(q) + CMP_W'(d) < CMP_W'(cols_eff);
        nb_calc  = c + ADDR_W'(d);
      end
      default: begin
        nb_valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    cnt_we    = 1'b0;
    cnt_wdata = acc;
    acc_ctrl  = '0;
    unique case (state)
      S_IDLE, S_EMIT: begin
        acc_ctrl.flag_clr = accept && (kind == KIND_START);
      end
      S_CMP: begin
        if (l == '0 || !match) begin
          cnt_we    = 1'b1;
          cnt_wdata = COUNT_W'(match);
        end else begin
          acc_ctrl.clear = 1'b1;
        end
      end
      S_NACC:  acc_ctrl.add = 1'b1;
      S_SUMB:  acc_ctrl.add = 1'b1;
      S_WRITE: cnt_we = 1'b1;
      default: begin
        cnt_we = 1'b0;
      end
    endcase
    if (state == S_CMP && last_layer && last_cell && (l == '0 || !match)) begin
      acc_ctrl.clear = 1'b1;
    end
    if (state == S_WRITE && last_layer && last_cell) begin
      acc_ctrl.clear = 1'b1;
    end
  end

  assign we0 = cnt_we && sel;
  assign we1 = cnt_we && !sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      grid_rows         <= DIM_W'(1);
      grid_cols         <= DIM_W'(1);
      jump_limit        <= JUMP_W'(1);
      grid_fill_pointer <= '0;
      word_length       <= '0;
      done              <= 1'b0;
      sel               <= 1'b0;
      dir               <= DIR_UP;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ROWS: grid_rows  <= cfg_data;
          REG_COLS: grid_cols  <= cfg_data;
          REG_JUMP: jump_limit <= cfg_data[JUMP_W-1:0];
          default: begin
          end
        endcase
      end
      if (grid_we) begin
        grid_fill_pointer <= grid_fill_pointer + FILL_W'(1);
      end
      if (word_we) begin
        word_length <= word_length + WLEN_W'(1);
      end
      unique case (state)
        S_IDLE, S_EMIT: begin
          if (state == S_EMIT) begin
            done       <= 1'b1;
            path_count <= acc;
            overflowed <= acc_flag;
          end
          state <= S_IDLE;
          if (accept && kind == KIND_START) begin
            c   <= '0;
            r   <= '0;
            q   <= '0;
            l   <= '0;
            sel <= 1'b0;
            if (word_length == '0) begin
              done       <= 1'b1;
              path_count <= '0;
              overflowed <= 1'b0;
            end else begin
              state <= S_CELL;
            end
          end
        end
        S_CELL: state <= S_CMP;
        S_NADDR, S_NACC: begin
          if (state == S_NADDR && nb_valid) begin
            nb_addr <= nb_calc;
            state   <= S_NREAD;
          end else if (nb_last) begin
            state <= S_WRITE;
          end else begin
            state <= S_NADDR;
            if (dir == DIR_RIGHT) begin
              dir   <= DIR_UP;
              d     <= d + JUMP_W'(1);
              dcols <= dcols + ADDR_W'(cols_eff);
            end else begin
              dir <= dir_t'(dir + 2'd1);
            end
          end
        end
        S_NREAD: state <= S_NACC;
        S_CMP, S_WRITE, S_SUMB: begin
          if (state == S_CMP && l != '0 && match) begin
            d     <= JUMP_W'(1);
            dcols <= ADDR_W'(cols_eff);
            dir   <= DIR_UP;
            state <= S_NADDR;
          end else if (last_cell) begin
            c       <= '0;
            r       <= '0;
            q       <= '0;
            nb_addr <= '0;
            if (state == S_SUMB) begin
              state <= S_EMIT;
            end else if (last_layer) begin
              sel   <= !sel;
              state <= S_SUMA;
            end else begin
              sel   <= !sel;
              l     <= l + WORD_AW'(1);
              state <= S_CELL;
            end
          end else begin
            c       <= c + ADDR_W'(1);
            nb_addr <= c + ADDR_W'(1);
            if (CMP_W'(q) + CMP_W'(1) == CMP_W'(cols_eff)) begin
              q <= '0;
              r <= r + ROW_W'(1);
            end else begin
              q <= q + COL_W'(1);
            end
            state <= (state == S_SUMB) ? S_SUMA : S_CELL;
          end
        end
        S_SUMA: state <= S_SUMB;
        default: state <= S_IDLE;
      endcase
    end
  end

  gwpc_ram #(.WIDTH(SYM_W), .DEPTH(CELLS)) u_grid (
    .clk(clk), .we(grid_we), .waddr(grid_fill_pointer[ADDR_W-1:0]), .wdata(symbol),
    .raddr(c), .rdata(grid_rdata)
  );

  gwpc_ram #(.WIDTH(SYM_W), .DEPTH(MAX_WORD)) u_word (
    .clk(clk), .we(word_we), .waddr(word_length[WORD_AW-1:0]), .wdata(symbol),
    .raddr(l), .rdata(word_rdata)
  );

  gwpc_ram #(.WIDTH(COUNT_W), .DEPTH(CELLS)) u_bank0 (
    .clk(clk), .we(we0), .waddr(c), .wdata(cnt_wdata),
    .raddr(nb_addr), .rdata(bank0_rdata)
  );

  gwpc_ram #(.WIDTH(COUNT_W), .DEPTH(CELLS)) u_bank1 (
    .clk(clk), .we(we1), .waddr(c), .wdata(cnt_wdata),
    .raddr(nb_addr), .rdata(bank1_rdata)
  );

  gwpc_acc u_acc (
    .clk(clk), .rst(rst), .ctrl(acc_ctrl), .operand(prev_rdata),
    .acc(acc), .flag(acc_flag)
  );

  a_bank_idle: assert property (@(posedge clk) disable iff (rst) !busy |-> !(we0 || we1))
    else $error("count memory written while idle");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    busy |-> !(grid_we || word_we))
    else $error("grid or word written during a run");
  a_one_bank: assert property (@(posedge clk) disable iff (rst) !(we0 && we1))
    else $error("both count banks written at once");

endmodule

`default_nettype wire
